/* rtl/deq_pkg.sv */
// shared constants, types and helpers for the deque with rotation
`timescale 1ns / 1ps

package deq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int VAL_W       = 32;
  localparam int DIV_BITS    = 15;
  localparam int STEP_W      = $clog2(DIV_BITS);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_ROTATE     = 3'd4;
  localparam logic [2:0] REQ_LIST       = 3'd5;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADCOUNT = 3'd2;
  localparam logic [2:0] ST_BADDIR   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // circular slot index add
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // bank 1 sits above bank 0
  function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
                                                  input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    a = {1'b0, idx};
    if (bank) begin
      a = a + ADDR_W'(QUEUE_DEPTH);
    end
    return a;
  endfunction

endpackage

/* rtl/deque_with_rotate.sv */
// top level: request decode, queue pointers and the list/rotate streamer
`timescale 1ns / 1ps

// bounded double-ended queue of signed 32-bit values with rotate and list.
// a request is taken when start is high and busy is low. every result shows
// on out_value/out_status/out_last_result for exactly one cycle with
// out_valid high and cannot be held off; out_last_result marks the final
// result of a request. pushes and error answers need no memory read, pops
// wait on one memory read. a list of n elements streams one memory read per
// cycle. a rotate first waits on the bit-serial remainder unit (15 shift
// steps, then its done strobe), then the same streaming pass, which copies
// the elements in rotated order into the other memory bank while they are
// listed. the store has no clearing pass; it is ready right after reset.

module deque_with_rotate
  import deq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_req_type,
  input  logic signed [VAL_W-1:0] in_push_value,
  input  logic [1:0]              in_rotate_dir,
  input  logic signed [15:0]      in_rotate_count,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value,
  output logic [2:0]              out_status,
  output logic                    out_last_result
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_POP_WAIT = 4'b0010,
    S_MOD      = 4'b0100,
    S_STREAM   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // queue pointers; bank_r selects the live copy of the store
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bank_r, bank_nxt;

  // streaming pass control
  logic             wr_back_r, wr_back_nxt;    // rotate: copy into other bank
  logic [2:0]       list_st_r, list_st_nxt;
  logic [1:0]       dir_r, dir_nxt;
  logic [IDX_W-1:0] src_r, src_nxt;            // logical source position
  logic [CNT_W-1:0] iss_r, iss_nxt;            // reads issued so far
  logic             p_valid_r, p_valid_nxt;    // read in flight
  logic [IDX_W-1:0] p_dst_r, p_dst_nxt;
  logic             p_last_r, p_last_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [2:0]       out_st_r, out_st_nxt;
  logic             out_last_r, out_last_nxt;

  mem_req_t         mreq;
  logic [VAL_W-1:0] rd_data;

  logic             mod_start;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;
  logic [CNT_W-1:0] shift_k;
  logic             is_full;
  logic             is_empty;
  logic             count_bad;
  logic [CNT_W-1:0] src_inc;

  deq_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  deq_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_rotate_count[DIV_BITS-1:0]),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign is_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count_r == '0);
  assign count_bad = in_rotate_count[15] || (in_rotate_count == 16'sd0);
  assign src_inc   = CNT_W'(src_r) + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    bank_nxt      = bank_r;
    wr_back_nxt   = wr_back_r;
    list_st_nxt   = list_st_r;
    dir_nxt       = dir_r;
    src_nxt       = src_r;
    iss_nxt       = iss_r;
    p_valid_nxt   = 1'b0;
    p_dst_nxt     = p_dst_r;
    p_last_nxt    = p_last_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    mod_start     = 1'b0;
    shift_k       = '0;
    mreq          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // default answer: one result, zero value, ok
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_st_nxt    = ST_OK;
          out_last_nxt  = 1'b1;
          iss_nxt       = '0;
          src_nxt       = '0;
          unique case (in_req_type)
            REQ_PUSH_FRONT: begin
              if (is_full) begin
                out_st_nxt = ST_FULL;
              end else begin
                front_nxt     = wrap_add(front_r, IDX_W'(QUEUE_DEPTH - 1));
                mreq.wr_en    = 1'b1;
                mreq.wr_addr  = mem_addr(bank_r, front_nxt);
                mreq.wr_data  = in_push_value;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            REQ_PUSH_BACK: begin
              if (is_full) begin
                out_st_nxt = ST_FULL;
              end else begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = mem_addr(bank_r, wrap_add(front_r, count_r[IDX_W-1:0]));
                mreq.wr_data = in_push_value;
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            REQ_POP_FRONT: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                mreq.rd_en    = 1'b1;
                mreq.rd_addr  = mem_addr(bank_r, front_r);
                front_nxt     = wrap_add(front_r, IDX_W'(1));
                count_nxt     = count_r - CNT_W'(1);
                state_nxt     = S_POP_WAIT;
              end
            end
            REQ_POP_BACK: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                mreq.rd_en    = 1'b1;
                mreq.rd_addr  = mem_addr(bank_r,
                                  wrap_add(front_r, IDX_W'(count_r - CNT_W'(1))));
                count_nxt     = count_r - CNT_W'(1);
                state_nxt     = S_POP_WAIT;
              end
            end
            REQ_ROTATE: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else if (count_bad) begin
                out_st_nxt = ST_BADCOUNT;
              end else if (in_rotate_dir != DIR_LEFT && in_rotate_dir != DIR_RIGHT) begin
                // bad direction: list as is, every result flagged
                out_valid_nxt = 1'b0;
                wr_back_nxt   = 1'b0;
                list_st_nxt   = ST_BADDIR;
                state_nxt     = S_STREAM;
              end else begin
                out_valid_nxt = 1'b0;
                wr_back_nxt   = 1'b1;
                list_st_nxt   = ST_OK;
                dir_nxt       = in_rotate_dir;
                mod_start     = 1'b1;
                state_nxt     = S_MOD;
              end
            end
            REQ_LIST: begin
              if (is_empty) begin
                out_st_nxt = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                wr_back_nxt   = 1'b0;
                list_st_nxt   = ST_OK;
                state_nxt     = S_STREAM;
              end
            end
            default: begin
              // unused request codes answer ok and change nothing
            end
          endcase
        end
      end

      S_POP_WAIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data;
        out_st_nxt    = ST_OK;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_MOD: begin
        if (mod_done) begin
          // right rotation by k is left rotation by n - k
          if (dir_r == DIR_RIGHT && mod_rem != '0) begin
            shift_k = count_r - mod_rem;
          end else begin
            shift_k = mod_rem;
          end
          src_nxt   = shift_k[IDX_W-1:0];
          state_nxt = S_STREAM;
        end
      end

      S_STREAM: begin
        // issue one read per cycle in rotated logical order
        if (iss_r != count_r) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = mem_addr(bank_r, wrap_add(front_r, src_r));
          src_nxt      = (src_inc == count_r) ? '0 : src_inc[IDX_W-1:0];
          iss_nxt      = iss_r + CNT_W'(1);
          p_valid_nxt  = 1'b1;
          p_dst_nxt    = iss_r[IDX_W-1:0];
          p_last_nxt   = (iss_r + CNT_W'(1) == count_r);
        end
        // data back: list it and, for a rotate, copy to the other bank
        if (p_valid_r) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_data;
          out_st_nxt    = list_st_r;
          out_last_nxt  = p_last_r;
          if (wr_back_r) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = mem_addr(~bank_r, wrap_add(front_r, p_dst_r));
            mreq.wr_data = rd_data;
          end
          if (p_last_r) begin
            if (wr_back_r) begin
              bank_nxt = ~bank_r;
            end
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      bank_r      <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      wr_back_r   <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      bank_r      <= bank_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      wr_back_r   <= wr_back_nxt;
      iss_r       <= iss_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    list_st_r   <= list_st_nxt;
    dir_r       <= dir_nxt;
    src_r       <= src_nxt;
    p_dst_r     <= p_dst_nxt;
    p_last_r    <= p_last_nxt;
    out_value_r <= out_value_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_status      = out_st_r;
  assign out_last_result = out_last_r;

endmodule

/* rtl/deq_mem.sv */
// two-bank element store, one write and one registered read per cycle
`timescale 1ns / 1ps

module deq_mem
  import deq_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem_r [0:2*QUEUE_DEPTH-1];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/deq_mod.sv */
// bit-serial remainder of the rotate count by the queue length
`timescale 1ns / 1ps

module deq_mod
  import deq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic                done,
  output logic [CNT_W-1:0]    rem
);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DIV_BITS-1:0] quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [CNT_W:0]      trial;
  logic [CNT_W-1:0]    rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[DIV_BITS-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CNT_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
